/* rtl/core/vt4_pkg.sv */
// Shared types and constants for the 4x4 vertex transform.
// Used by vt4_dot_lane and vertex_transform_4x4; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vt4_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FIX_W     = 32;
   localparam int NUM_ROWS  = 4;
   localparam int NUM_COLS  = 4;
   localparam int CSR_NUM   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 64;

   // Beat in to beat out: multiply, pair add, final add, shift and saturate
   localparam int PIPE_LAT  = 4;

   // Datapath widths: exact product, pair sum, full sum, shifted sum
   localparam int PROD_W  = 2 * FIX_W;
   localparam int PAIR_W  = PROD_W + 1;
   localparam int SUM_W   = PROD_W + 2;
   localparam int SHIFT_W = SUM_W - FRAC_BITS;

   typedef logic signed [FIX_W-1:0]   fix_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [PAIR_W-1:0]  pair_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [SHIFT_W-1:0] shift_type;
   typedef logic [CSR_W-1:0]          csr_word_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;

   localparam fix_type SAT_MAX = fix_type'({1'b0, {(FIX_W-1){1'b1}}});
   localparam fix_type SAT_MIN = fix_type'({1'b1, {(FIX_W-1){1'b0}}});

   // Register indexes
   localparam csr_idx_type REG_ROW0_COLS01 = 3'd0;
   localparam csr_idx_type REG_ROW0_COLS23 = 3'd1;
   localparam csr_idx_type REG_ROW1_COLS01 = 3'd2;
   localparam csr_idx_type REG_ROW1_COLS23 = 3'd3;
   localparam csr_idx_type REG_ROW2_COLS01 = 3'd4;
   localparam csr_idx_type REG_ROW2_COLS23 = 3'd5;
   localparam csr_idx_type REG_ROW3_COLS01 = 3'd6;
   localparam csr_idx_type REG_ROW3_COLS23 = 3'd7;

   localparam csr_word_type FIX_ONE_LO = csr_word_type'(1) << FRAC_BITS;
   localparam csr_word_type FIX_ONE_HI = FIX_ONE_LO << FIX_W;

   typedef struct packed {
      fix_type vec_x;
      fix_type vec_y;
      fix_type vec_z;
      fix_type vec_w;
   } req_type;

   typedef struct packed {
      fix_type out_x;
      fix_type out_y;
      fix_type out_z;
      fix_type out_w;
      logic    overflow;
   } rsp_type;

   // Identity matrix after reset
   function automatic csr_word_type csr_reset_value(input csr_idx_type idx);
      csr_word_type val;
      val = '0;
      case (idx)
         REG_ROW0_COLS01: val = FIX_ONE_LO;
         REG_ROW1_COLS01: val = FIX_ONE_HI;
         REG_ROW2_COLS23: val = FIX_ONE_LO;
         REG_ROW3_COLS23: val = FIX_ONE_HI;
         default:         val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/vt4_dot_lane.sv */
// One row of the transform: four exact products, a two-level add tree,
// floor shift and saturation, one register per stage. Depends on vt4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vt4_dot_lane
   import vt4_pkg::*;
(
   input  wire logic clock,
   input  fix_type   row [NUM_COLS],
   input  fix_type   vec [NUM_COLS],
   output fix_type   res,
   output logic      ovf
);

   prod_type  prod_ff [NUM_COLS];
   prod_type  prod_in [NUM_COLS];
   pair_type  pair_ff [2];
   pair_type  pair_in [2];
   sum_type   sum_ff;
   sum_type   sum_in;
   shift_type quo;
   fix_type   res_ff;
   fix_type   res_in;
   logic      ovf_ff;
   logic      ovf_in;
   logic [SHIFT_W-FIX_W:0] hi_bits;

   always_comb begin
      for (int i = 0; i < NUM_COLS; i++) begin
         prod_in[i] = prod_type'(row[i]) * prod_type'(vec[i]);
      end
      pair_in[0] = pair_type'(prod_ff[0]) + pair_type'(prod_ff[1]);
      pair_in[1] = pair_type'(prod_ff[2]) + pair_type'(prod_ff[3]);
      sum_in     = sum_type'(pair_ff[0]) + sum_type'(pair_ff[1]);
   end

   // Drop the fraction bits: arithmetic shift rounds toward minus infinity
   always_comb begin
      quo     = shift_type'(sum_ff[SUM_W-1:FRAC_BITS]);
      hi_bits = quo[SHIFT_W-1:FIX_W-1];
      ovf_in  = !((&hi_bits) || !(|hi_bits));
      if (ovf_in) begin
         res_in = quo[SHIFT_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         res_in = fix_type'(quo[FIX_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pair_ff <= pair_in;
      sum_ff  <= sum_in;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
   end

   assign res = res_ff;
   assign ovf = ovf_ff;

endmodule

`default_nettype wire

/* rtl/core/vertex_transform_4x4.sv */
// Vertex transform M*v: start reaches rsp_strobe through the registered steps
// (multiply, pair add, final add, shift and saturate), one vertex per cycle.
// These steps are the four-stage product/add pipeline in each row lane.
// busy stays low; results cannot be held off and appear for one cycle.
// Synchronous reset clears the valid pipeline and loads the identity matrix.
// Depends on vt4_pkg and vt4_dot_lane.
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_4x4
   import vt4_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  wire logic         csr_we,
   input  csr_idx_type       csr_index,
   input  csr_word_type      csr_wdata
);

   csr_word_type csr_ff [CSR_NUM];
   logic [PIPE_LAT-1:0] vld_ff;
   logic [PIPE_LAT-1:0] vld_in;
   fix_type vec [NUM_COLS];
   fix_type row [NUM_ROWS][NUM_COLS];
   fix_type res [NUM_ROWS];
   logic [NUM_ROWS-1:0] ovf;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_NUM; i++) begin
            csr_ff[i] <= csr_reset_value(csr_idx_type'(i));
         end
      end else if (csr_we) begin
         csr_ff[csr_index] <= csr_wdata;
      end
   end

   assign vld_in = {vld_ff[PIPE_LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign vec[0] = req_data.vec_x;
   assign vec[1] = req_data.vec_y;
   assign vec[2] = req_data.vec_z;
   assign vec[3] = req_data.vec_w;

   // Entry (r,c) sits in register 2r + c/2, low word for even c
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            row[r][c] = fix_type'(csr_ff[2*r + c/2][(c%2)*FIX_W +: FIX_W]);
         end
      end
   end

   for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
      vt4_dot_lane u_lane (
         .clock (clock),
         .row   (row[r]),
         .vec   (vec),
         .res   (res[r]),
         .ovf   (ovf[r])
      );
   end

   assign rsp_strobe        = vld_ff[PIPE_LAT-1];
   assign rsp_data.out_x    = res[0];
   assign rsp_data.out_y    = res[1];
   assign rsp_data.out_z    = res[2];
   assign rsp_data.out_w    = res[3];
   assign rsp_data.overflow = |ovf;

   a_strobe_from_start: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, PIPE_LAT))
      else $error("result beat without a matching start");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.overflow) |->
         (rsp_data.out_x == SAT_MAX || rsp_data.out_x == SAT_MIN ||
          rsp_data.out_y == SAT_MAX || rsp_data.out_y == SAT_MIN ||
          rsp_data.out_z == SAT_MAX || rsp_data.out_z == SAT_MIN ||
          rsp_data.out_w == SAT_MAX || rsp_data.out_w == SAT_MIN))
      else $error("overflow flag without a saturated component");

   a_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##(PIPE_LAT-1) rsp_strobe)
      else $error("accepted vertex lost in pipeline");

endmodule

`default_nettype wire
